[hdl/macs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package macs_pkg;

  localparam int NUM_INST   = 16;
  localparam int INST_W     = 4;
  localparam int MAX_WIN    = 256;
  localparam int SLOT_W     = 8;
  localparam int SPAN_W     = 9;
  localparam int TRACK_W    = 5;
  localparam int PRICE_W    = 32;
  localparam int STAMP_W    = 64;
  localparam int SUM_W      = 40;
  localparam int PROD_W     = SUM_W + SPAN_W;
  localparam int ADDR_W     = INST_W + SLOT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACKED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG    = 2'd2;

  localparam logic DIR_LONG  = 1'b0;
  localparam logic DIR_SHORT = 1'b1;

  typedef struct packed {
    logic [INST_W-1:0]  instrument;
    logic [PRICE_W-1:0] close_price;
    logic [STAMP_W-1:0] stamp;
  } macs_in_t;

  typedef struct packed {
    logic [INST_W-1:0]  signal_instrument;
    logic [STAMP_W-1:0] signal_stamp;
    logic               direction;
  } macs_out_t;

  function automatic logic [SPAN_W-1:0] long_eff(input logic [SPAN_W-1:0] sp);
    logic [SPAN_W-1:0] r;
    r = sp;
    if (sp == '0) r = SPAN_W'(1);
    else if (sp > SPAN_W'(MAX_WIN)) r = SPAN_W'(MAX_WIN);
    return r;
  endfunction

  function automatic logic [SPAN_W-1:0] short_eff(input logic [SPAN_W-1:0] sp,
                                                  input logic [SPAN_W-1:0] l);
    logic [SPAN_W-1:0] r;
    r = sp;
    if (sp == '0) r = SPAN_W'(1);
    if (r > l) r = l;
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/macs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module macs_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire macs_pkg::macs_in_t       in_word,
  input  wire logic [macs_pkg::TRACK_W-1:0] tracked,
  output logic                          q_valid,
  output macs_pkg::macs_in_t            q_word,
  input  wire logic                     q_pop
);
  import macs_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  macs_in_t           fifo_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r, rptr_r;
  logic [PTR_W:0]     count_r;
  logic               push;

  // Ticks for instruments that are not tracked are taken and dropped here.
  assign in_stall = (count_r == (PTR_W+1)'(DEPTH));
  assign push     = in_valid && !in_stall &&
                    ({1'b0, in_word.instrument} < tracked);
  assign q_valid  = (count_r != '0);
  assign q_word   = fifo_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) fifo_r[wptr_r] <= in_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (q_pop) rptr_r <= rptr_r + 1'b1;
      if (push && !q_pop) count_r <= count_r + 1'b1;
      else if (!push && q_pop) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

[hdl/macs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module macs_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire macs_pkg::macs_in_t           q_word,
  output logic                              q_pop,
  input  wire logic [macs_pkg::SPAN_W-1:0]  short_span,
  input  wire logic [macs_pkg::SPAN_W-1:0]  long_span,
  input  wire logic                         span_wr,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output macs_pkg::macs_out_t               out_word
);
  import macs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_S, ST_RD_L, ST_SWEEP, ST_SUM, ST_MUL, ST_CMP
  } state_t;

  state_t             state_r;
  macs_in_t           cur_r;
  logic [SLOT_W-1:0]  slot_r  [NUM_INST];
  logic [SPAN_W-1:0]  fill_r  [NUM_INST];
  logic [SUM_W-1:0]   sum_s_r [NUM_INST];
  logic [SUM_W-1:0]   sum_l_r [NUM_INST];
  logic [NUM_INST-1:0] valid_r;

  logic [PRICE_W-1:0] mem [NUM_INST*MAX_WIN];
  logic [PRICE_W-1:0] rdata_r;
  logic [ADDR_W-1:0]  raddr;
  logic               mem_we;

  logic [PRICE_W-1:0] old_s_r;
  logic [SPAN_W-1:0]  cnt_r;
  logic [SUM_W-1:0]   acc_s_r, acc_l_r, acc_s_nxt, acc_l_nxt;
  logic [SUM_W-1:0]   ps_r, pl_r, cs_r, cl_r, new_cs, new_cl;
  logic [PROD_W-1:0]  pa_r, pb_r, ca_r, cb_r;
  logic               out_valid_r;
  macs_out_t          out_word_r;

  logic [INST_W-1:0]  k;
  logic [SPAN_W-1:0]  l_eff, s_eff, fill_cl, fill_new;
  logic               out_free, up, down;

  assign k        = cur_r.instrument;
  assign l_eff    = long_eff(long_span);
  assign s_eff    = short_eff(short_span, l_eff);
  assign fill_cl  = (fill_r[k] > l_eff) ? l_eff : fill_r[k];
  assign fill_new = (fill_cl < l_eff) ? fill_cl + 1'b1 : fill_cl;
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign mem_we   = (state_r == ST_RD_L);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    unique case (state_r)
      ST_RD_S:  raddr = {k, slot_r[k] - s_eff[SLOT_W-1:0]};
      ST_RD_L:  raddr = {k, slot_r[k] - l_eff[SLOT_W-1:0]};
      default:  raddr = {k, slot_r[k] - SLOT_W'(1) - cnt_r[SLOT_W-1:0]};
    endcase
  end

  // Sweep data arriving at count c belongs to the (c-1)th newest price.
  always_comb begin
    acc_l_nxt = acc_l_r + SUM_W'(rdata_r);
    acc_s_nxt = (cnt_r <= s_eff) ? acc_s_r + SUM_W'(rdata_r) : acc_s_r;
  end

  assign new_cs = sum_s_r[k] + SUM_W'(cur_r.close_price) - SUM_W'(old_s_r);
  assign new_cl = sum_l_r[k] + SUM_W'(cur_r.close_price) - SUM_W'(rdata_r);

  assign up   = !(pa_r > pb_r) && (ca_r > cb_r);
  assign down = !(pa_r < pb_r) && (ca_r < cb_r);

  always_ff @(posedge clk) begin
    if (mem_we) mem[{k, slot_r[k]}] <= cur_r.close_price;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      cnt_r       <= '0;
      for (int i = 0; i < NUM_INST; i++) begin
        slot_r[i]  <= '0;
        fill_r[i]  <= '0;
        sum_s_r[i] <= '0;
        sum_l_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (span_wr) valid_r <= '0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            cur_r   <= q_word;
            state_r <= ST_RD_S;
          end
        end
        ST_RD_S: state_r <= ST_RD_L;
        ST_RD_L: begin
          old_s_r   <= rdata_r;
          slot_r[k] <= slot_r[k] + 1'b1;
          fill_r[k] <= fill_new;
          cnt_r     <= '0;
          acc_s_r   <= '0;
          acc_l_r   <= '0;
          if (fill_new != l_eff) begin
            valid_r[k] <= 1'b0;
            state_r    <= ST_IDLE;
          end else if (valid_r[k]) begin
            state_r <= ST_SUM;
          end else begin
            state_r <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r != '0) begin
            acc_s_r <= acc_s_nxt;
            acc_l_r <= acc_l_nxt;
          end
          if (cnt_r == l_eff) begin
            ps_r       <= sum_s_r[k];
            pl_r       <= sum_l_r[k];
            cs_r       <= acc_s_nxt;
            cl_r       <= acc_l_nxt;
            sum_s_r[k] <= acc_s_nxt;
            sum_l_r[k] <= acc_l_nxt;
            valid_r[k] <= 1'b1;
            state_r    <= ST_MUL;
          end
        end
        ST_SUM: begin
          ps_r       <= sum_s_r[k];
          pl_r       <= sum_l_r[k];
          cs_r       <= new_cs;
          cl_r       <= new_cl;
          sum_s_r[k] <= new_cs;
          sum_l_r[k] <= new_cl;
          state_r    <= ST_MUL;
        end
        ST_MUL: begin
          pa_r    <= PROD_W'(ps_r) * PROD_W'(l_eff);
          pb_r    <= PROD_W'(pl_r) * PROD_W'(s_eff);
          ca_r    <= PROD_W'(cs_r) * PROD_W'(l_eff);
          cb_r    <= PROD_W'(cl_r) * PROD_W'(s_eff);
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (out_free) begin
            // A previous pair of zero sums means there is no earlier average.
            if (!(ps_r == '0 && pl_r == '0) && (up || down)) begin
              out_valid_r                  <= 1'b1;
              out_word_r.signal_instrument <= k;
              out_word_r.signal_stamp      <= cur_r.stamp;
              out_word_r.direction         <= up ? DIR_LONG : DIR_SHORT;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/moving_average_crossover_signal.sv]
// Moving-average crossover detector for up to 16 instruments.
// Input words (in_valid/in_stall) carry instrument, close price and stamp;
// ticks for instruments at or above tracked_count are taken and dropped.
// Result words (out_valid/out_stall) carry the instrument, the stamp of the
// tick that caused the cross and the direction (0 long, 1 short).
// Configuration is written on cfg_valid/cfg_ready (always ready), index 0
// tracked count, 1 short span, 2 long span; other indexes are ignored.
// A four-entry queue decouples input from the sequencer, so words are taken
// while earlier ones are still being worked on.
// In the sequencer, a tick whose window is still filling ends after its two
// price-memory reads; once full, a tick updates both window sums from the
// prices that leave them, except on the tick that first fills the window or
// the first full tick after a span write, where both window sums are rebuilt
// by reading L stored prices; full ticks then go to multiply and compare.
// Reset clears all per-instrument state and loads 16 / 10 / 30; the price
// memory itself is not cleared. While out_stall holds a result, the
// sequencer waits at its compare step and the queue keeps filling.
`timescale 1ns / 1ps
`default_nettype none
module moving_average_crossover_signal (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire macs_pkg::macs_in_t               in_word,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output macs_pkg::macs_out_t                   out_word,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [macs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [macs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import macs_pkg::*;

  logic [TRACK_W-1:0] tracked_r;
  logic [SPAN_W-1:0]  short_r, long_r;
  logic               q_valid, q_pop, span_wr;
  macs_in_t           q_word;

  assign cfg_ready = 1'b1;
  assign span_wr   = cfg_valid && (cfg_index == CFG_SHORT || cfg_index == CFG_LONG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracked_r <= TRACK_W'(16);
      short_r   <= SPAN_W'(10);
      long_r    <= SPAN_W'(30);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TRACKED: tracked_r <= cfg_data[TRACK_W-1:0];
        CFG_SHORT:   short_r   <= cfg_data;
        CFG_LONG:    long_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  macs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .tracked  (tracked_r),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  macs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_word     (q_word),
    .q_pop      (q_pop),
    .short_span (short_r),
    .long_span  (long_r),
    .span_wr    (span_wr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import macs_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE_CYCLES = 1500;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  macs_in_t in_word;
  logic out_valid;
  logic out_stall;
  macs_out_t out_word;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  moving_average_crossover_signal u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block's registers and per-instrument state.
  logic [TRACK_W-1:0] trk_count;
  logic [SPAN_W-1:0] short_reg;
  logic [SPAN_W-1:0] long_reg;
  logic [PRICE_W-1:0] price_hist [NUM_INST][MAX_WIN];
  logic [SLOT_W-1:0] next_slot [NUM_INST];
  int unsigned fill_cnt [NUM_INST];
  longint unsigned last_short_sum [NUM_INST];
  longint unsigned last_long_sum [NUM_INST];

  macs_out_t pending_signals[$];
  int err_count;
  int cycle_count;
  int burst_left;
  int stall_pct;

  initial begin
    clk = 1'b0;
  end
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  function automatic int cmp_wide(input longint unsigned a, input longint unsigned b);
    if (a < b) return -1;
    if (a > b) return 1;
    return 0;
  endfunction

  task automatic predict_tick(input macs_in_t w);
    int unsigned k;
    int unsigned span_l;
    int unsigned span_s;
    logic [SLOT_W-1:0] idx;
    longint unsigned cs;
    longint unsigned cl;
    longint unsigned ps;
    longint unsigned pl;
    int pc;
    int cc;
    macs_out_t r;
    if (w.instrument >= trk_count) return;
    k = w.instrument;
    span_l = long_reg;
    if (span_l < 1) span_l = 1;
    if (span_l > MAX_WIN) span_l = MAX_WIN;
    span_s = short_reg;
    if (span_s < 1) span_s = 1;
    if (span_s > span_l) span_s = span_l;
    price_hist[k][next_slot[k]] = w.close_price;
    next_slot[k] = next_slot[k] + SLOT_W'(1);
    if (fill_cnt[k] > span_l) fill_cnt[k] = span_l;
    if (fill_cnt[k] < span_l) fill_cnt[k]++;
    if (fill_cnt[k] < span_l) return;
    cs = 0;
    cl = 0;
    for (int i = 0; i < span_l; i++) begin
      idx = next_slot[k] - SLOT_W'(1) - SLOT_W'(i);
      cl += price_hist[k][idx];
      if (i < span_s) cs += price_hist[k][idx];
    end
    ps = last_short_sum[k];
    pl = last_long_sum[k];
    last_short_sum[k] = cs;
    last_long_sum[k] = cl;
    if (ps == 0 && pl == 0) return;
    // Averages are compared as sum_short * L against sum_long * S.
    pc = cmp_wide(ps * span_l, pl * span_s);
    cc = cmp_wide(cs * span_l, cl * span_s);
    r.signal_instrument = w.instrument;
    r.signal_stamp = w.stamp;
    if (pc <= 0 && cc > 0) begin
      r.direction = DIR_LONG;
      pending_signals.insert(pending_signals.size(), r);
    end else if (pc >= 0 && cc < 0) begin
      r.direction = DIR_SHORT;
      pending_signals.insert(pending_signals.size(), r);
    end
  endtask

  task automatic send_tick(input macs_in_t w);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tick(w);
  endtask

  task automatic send_fields(input int inst, input logic [31:0] price,
                             input logic [63:0] stamp);
    macs_in_t w;
    w.instrument = inst[INST_W-1:0];
    w.close_price = price;
    w.stamp = stamp;
    send_tick(w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TRACKED: trk_count = val[TRACK_W-1:0];
      CFG_SHORT: short_reg = val;
      CFG_LONG: long_reg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending, wait for every outstanding signal, then let ticks that
  // produce nothing finish inside the block.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_signals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_spans(input int trk, input int s, input int l);
    drain();
    write_reg(CFG_TRACKED, CFG_DATA_W'(trk));
    write_reg(CFG_SHORT, CFG_DATA_W'(s));
    write_reg(CFG_LONG, CFG_DATA_W'(l));
  endtask

  task automatic send_random(input int count, input int inst_hi);
    logic [31:0] price;
    int inst;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) price = $urandom;
      else if (pick < 14) price = 32'd0;
      else price = $urandom_range(0, 1000);
      if ($urandom_range(0, 9) == 0) inst = $urandom_range(0, 15);
      else inst = $urandom_range(0, inst_hi);
      send_fields(inst, price, {$urandom, $urandom});
    end
  endtask

  task automatic test_reset_defaults;
    send_random(90, 1);
  endtask

  task automatic test_directed_cross;
    set_spans(4, 2, 3);
    send_fields(0, 32'd10, 64'd1);
    send_fields(0, 32'd10, 64'd2);
    send_fields(0, 32'd10, 64'd3);
    send_fields(0, 32'd100, 64'hFFFF_FFFF_FFFF_FFFF);
    send_fields(0, 32'd0, 64'd5);
    send_fields(0, 32'd0, 64'd0);
    send_fields(15, 32'hFFFF_FFFF, 64'd7);
    send_fields(4, 32'd55, 64'd8);
    send_fields(3, 32'hFFFF_FFFF, 64'hAAAA_5555_AAAA_5555);
    send_fields(3, 32'hFFFF_FFFF, 64'h5555_AAAA_5555_AAAA);
    send_fields(3, 32'hFFFF_FFFF, 64'd11);
    send_fields(3, 32'd0, 64'd12);
    send_fields(3, 32'hFFFF_FFFF, 64'd13);
  endtask

  task automatic test_span_clamps;
    set_spans(2, 0, 0);
    // An index past the register list must change nothing.
    write_reg(CFG_IDX_W'(3), CFG_DATA_W'(1));
    for (int n = 0; n < 4; n++) send_fields(1, $urandom_range(0, 50), {$urandom, $urandom});
    set_spans(31, 0, 2);
    send_random(80, 15);
  endtask

  task automatic test_random_mix;
    set_spans(16, 3, 8);
    send_random(150, 15);
    set_spans(10, 5, 5);
    send_random(40, 9);
  endtask

  task automatic test_widest_window;
    // Long span above the ring size clamps to the ring size.
    set_spans(1, 255, 300);
    send_random(270, 0);
    set_spans(16, 1, 2);
    send_random(20, 15);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_signals.size() == 0) begin
        report_mismatch("signal with none expected");
      end else begin
        if (out_word.signal_instrument !== pending_signals[0].signal_instrument)
          report_mismatch($sformatf("instrument %0d, expected %0d",
            out_word.signal_instrument, pending_signals[0].signal_instrument));
        if (out_word.signal_stamp !== pending_signals[0].signal_stamp)
          report_mismatch($sformatf("stamp %h, expected %h",
            out_word.signal_stamp, pending_signals[0].signal_stamp));
        if (out_word.direction !== pending_signals[0].direction)
          report_mismatch($sformatf("direction %0d, expected %0d",
            out_word.direction, pending_signals[0].direction));
        pending_signals.delete(0);
      end
    end
  end

  // The receiver periodically picks a new stall rate of 0, 25, 60 or 90 percent.
  always @(negedge clk) begin
    if (cycle_count % 300 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    err_count = 0;
    cycle_count = 0;
    burst_left = 0;
    stall_pct = 0;
    trk_count = TRACK_W'(16);
    short_reg = SPAN_W'(10);
    long_reg = SPAN_W'(30);
    for (int k = 0; k < NUM_INST; k++) begin
      next_slot[k] = '0;
      fill_cnt[k] = 0;
      last_short_sum[k] = 0;
      last_long_sum[k] = 0;
      for (int j = 0; j < MAX_WIN; j++) price_hist[k][j] = '0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_directed_cross();
    test_span_clamps();
    test_random_mix();
    test_widest_window();
    drain();

    if (pending_signals.size() != 0)
      report_mismatch($sformatf("%0d signals never arrived", pending_signals.size()));
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/macs_pkg.sv
hdl/macs_front.sv
hdl/macs_back.sv
hdl/moving_average_crossover_signal.sv
verif/tb_top.sv
